// ----- sv/rst_pkg.sv -----
// Shared types and constants for the source tokenizer.
`default_nettype none
package rst_pkg;
  localparam logic [3:0] K_SYM = 4'd0, K_NUM = 4'd1, K_STR = 4'd2, K_HEX = 4'd3,
    K_BIN = 4'd4, K_ARITH = 4'd5, K_CMP = 4'd6, K_LOGIC = 4'd7, K_NOT = 4'd8,
    K_LPAR = 4'd9, K_RPAR = 4'd10, K_COMMA = 4'd11, K_SEMI = 4'd12, K_EOC = 4'd13,
    K_EOF = 4'd14, K_ERR = 4'd15;
  localparam logic [2:0] E_NONE = 3'd0, E_CHAR = 3'd1, E_CMNT = 3'd2, E_STR = 3'd3,
    E_HEX = 3'd4, E_ODDHEX = 3'd5, E_BIN = 3'd6, E_GRP = 3'd7;
  localparam logic [3:0] M_IDLE = 4'd0, M_SLASH = 4'd1, M_DOT = 4'd2, M_COMMENT = 4'd3,
    M_CSLASH = 4'd4, M_CSTAR = 4'd5, M_STRING = 4'd6, M_SQUOTE = 4'd7, M_SYM = 4'd8,
    M_SYMEXP = 4'd9;
  localparam logic [2:0] D_NONE = 3'd0, D_DIG = 3'd1, D_DOT = 3'd2, D_DIGDOT = 3'd3,
    D_E = 3'd4, D_ES = 3'd5, D_EX = 3'd6, D_BAD = 3'd7;
  localparam logic [4:0] KIND_NONE = 5'd16;
  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic        comp;
    logic        cons;
    logic        dbl;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [2:0]  err;
  } rec_t;

  typedef struct packed {
    logic [2:0] cnt;
    rec_t [MAX_RES-1:0] rec;
  } batch_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction
endpackage
`default_nettype wire

// ----- sv/rst_front.sv -----
// Front part: scanner state machine, builds the records caused by one request.
`default_nettype none
module rst_front import rst_pkg::*; #(
  parameter int unsigned MAX_COMMENT_DEPTH = 255,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       present_i,
  input  wire logic       eos_i,
  output batch_t          batch_o
);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam int unsigned DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(MAX_COMMENT_DEPTH);

  logic [3:0] mode_q, mode_d;
  logic [7:0] quote_q, quote_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, ooff_q, ooff_d;
  logic [15:0] line_q, line_d, col_q, col_d, oline_q, oline_d, ocol_q, ocol_d, olen_q, olen_d;
  logic [DW-1:0] depth_q, depth_d;
  logic dbl_q, dbl_d, hexok_q, hexok_d, hpar_q, hpar_d, binok_q, binok_d;
  logic [1:0] bcnt_q, bcnt_d;
  logic cons_q, cons_d, comp_q, comp_d, preve_q, preve_d;
  logic [2:0] dfa_q, dfa_d;
  logic [4:0] last_q, last_d;
  logic err_q, err_d;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_xd(input logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic is_sp(input logic [7:0] c);
    return c == "_" || c == "@" || c == "#" || c == "$" || c == "?" || c == "!";
  endfunction
  function automatic logic [2:0] dfa_step(input logic [2:0] s, input logic [7:0] c);
    logic dg, e;
    dg = is_dig(c);
    e = (c == "E" || c == "e");
    case (s)
      D_NONE:   return dg ? D_DIG : (c == "." ? D_DOT : D_BAD);
      D_DOT:    return dg ? D_DIGDOT : D_BAD;
      D_DIG:    return dg ? D_DIG : (c == "." ? D_DIGDOT : (e ? D_E : D_BAD));
      D_DIGDOT: return dg ? D_DIGDOT : (e ? D_E : D_BAD);
      D_E:      return dg ? D_EX : ((c == "+" || c == "-") ? D_ES : D_BAD);
      D_ES, D_EX: return dg ? D_EX : D_BAD;
      default:  return D_BAD;
    endcase
  endfunction
  function automatic logic [15:0] clamp(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  batch_t b;

  always_comb begin
    logic redo;
    logic [7:0] c;
    logic [3:0] k;
    rec_t r;
    int unsigned p;

    mode_d = mode_q; quote_d = quote_q; off_d = off_q; line_d = line_q; col_d = col_q;
    ooff_d = ooff_q; oline_d = oline_q; ocol_d = ocol_q; olen_d = olen_q;
    depth_d = depth_q; dbl_d = dbl_q; hexok_d = hexok_q; hpar_d = hpar_q;
    binok_d = binok_q; bcnt_d = bcnt_q; cons_d = cons_q; comp_d = comp_q;
    preve_d = preve_q; dfa_d = dfa_q; last_d = last_q; err_d = err_q;
    b = '0;
    c = byte_i;
    k = K_SYM;
    redo = 1'b0;
    r = '0;

    // Each emission appends to b at b.cnt.
    if (req_i && present_i && !err_q) begin
      redo = 1'b1;
      for (p = 0; p < 3; p++) begin
        if (redo && !err_d) begin
          redo = 1'b0;
          r = '0;
          case (mode_d)
            M_SLASH: begin
              if (c == "*") begin
                depth_d = DW'(1);
                mode_d = M_COMMENT;
              end else begin
                r.kind = K_ARITH; r.off = clamp(ooff_d); r.len = 16'd1;
                r.line = oline_d; r.col = ocol_d;
                b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, K_ARITH};
                mode_d = M_IDLE; redo = 1'b1;
              end
            end
            M_DOT: begin
              if (is_dig(c)) begin
                cons_d = 1'b1; comp_d = 1'b1; preve_d = 1'b0;
                dfa_d = dfa_step(D_DOT, c); olen_d = 16'd2; mode_d = M_SYM;
              end else begin
                r.kind = K_ERR; r.err = E_CHAR; r.line = oline_d; r.col = ocol_d;
                b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, K_ERR};
                err_d = 1'b1;
              end
            end
            M_COMMENT: begin
              if (c == "/") mode_d = M_CSLASH;
              else if (c == "*") mode_d = M_CSTAR;
            end
            M_CSLASH: begin
              mode_d = M_COMMENT;
              if (c == "*") begin
                if (depth_d < DMAX) depth_d = depth_d + DW'(1);
              end else redo = 1'b1;
            end
            M_CSTAR: begin
              mode_d = M_COMMENT;
              if (c == "/") begin
                if (depth_d != '0) depth_d = depth_d - DW'(1);
                if (depth_d == '0) mode_d = M_IDLE;
              end else redo = 1'b1;
            end
            M_STRING: begin
              if (c == quote_d) mode_d = M_SQUOTE;
              else if (c == 8'h0A) begin
                r.kind = K_ERR; r.err = E_STR; r.line = oline_d; r.col = ocol_d;
                b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, K_ERR};
                err_d = 1'b1;
              end else begin
                olen_d = inc16(olen_d);
                if (c != " " && c != 8'h09) begin
                  if (!is_xd(c)) hexok_d = 1'b0;
                  hpar_d = ~hpar_d;
                  if (c != "0" && c != "1") binok_d = 1'b0;
                  bcnt_d = bcnt_d + 2'd1;
                end
              end
            end
            M_SQUOTE: begin
              if (c == quote_d) begin
                dbl_d = 1'b1;
                olen_d = inc16(inc16(olen_d));
                if (c != " " && c != 8'h09) begin
                  if (!is_xd(c)) hexok_d = 1'b0;
                  if (c != "0" && c != "1") binok_d = 1'b0;
                  bcnt_d = bcnt_d + 2'd2;
                end
                mode_d = M_STRING;
              end else begin
                r.line = oline_d; r.col = ocol_d;
                if (c == "x" || c == "X") begin
                  r.err = !hexok_d ? E_HEX : (hpar_d ? E_ODDHEX : E_NONE);
                  k = K_HEX;
                end else if (c == "b" || c == "B") begin
                  r.err = !binok_d ? E_BIN : (bcnt_d != 2'd0 ? E_GRP : E_NONE);
                  k = K_BIN;
                end else begin
                  k = K_STR;
                  redo = 1'b1;
                end
                if (r.err != E_NONE) begin
                  r.kind = K_ERR; err_d = 1'b1;
                end else begin
                  r.kind = k; r.dbl = dbl_d; r.len = olen_d;
                  r.off = clamp((ooff_d < OFF_MAX) ? ooff_d + 1'b1 : OFF_MAX);
                  mode_d = M_IDLE;
                end
                b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, r.kind};
              end
            end
            M_SYM, M_SYMEXP: begin
              if (mode_d == M_SYM ? (is_alp(c) || is_dig(c) || is_sp(c) || c == ".")
                                  : is_dig(c)) begin
                dfa_d = dfa_step(dfa_d, c); olen_d = inc16(olen_d);
                if (c == ".") comp_d = 1'b1;
                preve_d = (c == "E" || c == "e");
              end else if (mode_d == M_SYM && cons_d && preve_d && (c == "+" || c == "-")) begin
                dfa_d = dfa_step(dfa_d, c); olen_d = inc16(olen_d);
                preve_d = 1'b0; mode_d = M_SYMEXP;
              end else begin
                r.kind = (cons_d && (dfa_d == D_DIG || dfa_d == D_DIGDOT || dfa_d == D_EX))
                         ? K_NUM : K_SYM;
                r.comp = comp_d; r.cons = cons_d; r.off = clamp(ooff_d); r.len = olen_d;
                r.line = oline_d; r.col = ocol_d;
                b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, r.kind};
                mode_d = M_IDLE; redo = 1'b1;
              end
            end
            default: begin
              mode_d = M_IDLE;
              if (c == 8'h0A) begin
                if (last_d != KIND_NONE && last_d != {1'b0, K_COMMA} &&
                    last_d != {1'b0, K_EOC}) begin
                  r.kind = K_EOC; r.off = clamp(off_q); r.line = line_q; r.col = col_q;
                  b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, K_EOC};
                end
              end else if (c != " " && c != 8'h09 && c != 8'h0D) begin
                ooff_d = off_q; oline_d = line_q; ocol_d = col_q; olen_d = '0;
                if (c == "/") mode_d = M_SLASH;
                else if (c == ".") mode_d = M_DOT;
                else if (c == "'" || c == 8'h22) begin
                  quote_d = c; dbl_d = 1'b0; hexok_d = 1'b1; hpar_d = 1'b0;
                  binok_d = 1'b1; bcnt_d = 2'd0; mode_d = M_STRING;
                end else if (is_alp(c) || is_sp(c) || is_dig(c)) begin
                  cons_d = is_dig(c); comp_d = 1'b0; preve_d = (c == "E" || c == "e");
                  dfa_d = dfa_step(D_NONE, c); olen_d = 16'd1; mode_d = M_SYM;
                end else begin
                  r.line = line_q; r.col = col_q;
                  case (c)
                    "\\": r.kind = K_NOT;
                    "(": r.kind = K_LPAR;
                    ")": r.kind = K_RPAR;
                    ",": r.kind = K_COMMA;
                    ";", ":": r.kind = K_SEMI;
                    "+", "-", "*", "%": r.kind = K_ARITH;
                    "=", ">", "<": r.kind = K_CMP;
                    "&", "|": r.kind = K_LOGIC;
                    default: begin
                      r.kind = K_ERR; r.err = E_CHAR;
                    end
                  endcase
                  if (r.kind == K_ERR) err_d = 1'b1;
                  else begin
                    r.off = clamp(off_q); r.len = 16'd1;
                  end
                  b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, r.kind};
                end
              end
            end
          endcase
        end
      end
      if (off_q < OFF_MAX) off_d = off_q + 1'b1;
      if (c == 8'h0A) begin
        line_d = inc16(line_q); col_d = 16'd1;
      end else col_d = inc16(col_q);
    end

    if (req_i && eos_i) begin
      if (!err_d) begin
        r = '0;
        r.line = oline_d; r.col = ocol_d;
        case (mode_d)
          M_SLASH: begin
            r.kind = K_ARITH; r.off = clamp(ooff_d); r.len = 16'd1;
          end
          M_DOT: begin
            r.kind = K_ERR; r.err = E_CHAR;
          end
          M_COMMENT, M_CSLASH, M_CSTAR: begin
            r.kind = K_ERR; r.err = E_CMNT; r.line = line_d; r.col = col_d;
          end
          M_STRING: begin
            r.kind = K_ERR; r.err = E_STR;
          end
          M_SQUOTE: begin
            r.kind = K_STR; r.dbl = dbl_d; r.len = olen_d;
            r.off = clamp((ooff_d < OFF_MAX) ? ooff_d + 1'b1 : OFF_MAX);
          end
          M_SYM, M_SYMEXP: begin
            r.kind = (cons_d && (dfa_d == D_DIG || dfa_d == D_DIGDOT || dfa_d == D_EX))
                     ? K_NUM : K_SYM;
            r.comp = comp_d; r.cons = cons_d; r.off = clamp(ooff_d); r.len = olen_d;
          end
          default: r.kind = K_EOF;
        endcase
        if (r.kind != K_EOF) begin
          b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1; last_d = {1'b0, r.kind};
          if (r.kind == K_ERR) err_d = 1'b1;
        end
        if (!err_d) begin
          r = '0;
          r.off = clamp(off_d); r.line = line_d; r.col = col_d;
          if (last_d != KIND_NONE && last_d != {1'b0, K_EOC}) begin
            r.kind = K_EOC;
            b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1;
          end
          r.kind = K_EOF;
          b.rec[b.cnt[1:0]] = r; b.cnt = b.cnt + 3'd1;
        end
      end
      mode_d = M_IDLE; quote_d = '0; off_d = '0; line_d = 16'd1; col_d = 16'd1;
      ooff_d = '0; oline_d = '0; ocol_d = '0; olen_d = '0; depth_d = '0;
      dbl_d = 1'b0; hexok_d = 1'b0; hpar_d = 1'b0; binok_d = 1'b0; bcnt_d = '0;
      cons_d = 1'b0; comp_d = 1'b0; preve_d = 1'b0; dfa_d = D_NONE;
      last_d = KIND_NONE; err_d = 1'b0;
    end
  end

  assign batch_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; quote_q <= '0; off_q <= '0; line_q <= 16'd1; col_q <= 16'd1;
      ooff_q <= '0; oline_q <= '0; ocol_q <= '0; olen_q <= '0; depth_q <= '0;
      dbl_q <= 1'b0; hexok_q <= 1'b0; hpar_q <= 1'b0; binok_q <= 1'b0; bcnt_q <= '0;
      cons_q <= 1'b0; comp_q <= 1'b0; preve_q <= 1'b0; dfa_q <= D_NONE;
      last_q <= KIND_NONE; err_q <= 1'b0;
    end else if (req_i) begin
      mode_q <= mode_d; quote_q <= quote_d; off_q <= off_d; line_q <= line_d;
      col_q <= col_d; ooff_q <= ooff_d; oline_q <= oline_d; ocol_q <= ocol_d;
      olen_q <= olen_d; depth_q <= depth_d; dbl_q <= dbl_d; hexok_q <= hexok_d;
      hpar_q <= hpar_d; binok_q <= binok_d; bcnt_q <= bcnt_d; cons_q <= cons_d;
      comp_q <= comp_d; preve_q <= preve_d; dfa_q <= dfa_d; last_q <= last_d;
      err_q <= err_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/rst_back.sv -----
// Back part: batch queue and serializer that hands records out one per pop.
`default_nettype none
module rst_back import rst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  batch_t     batch_i,
  output logic       full_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output rec_t       rec_o,
  output logic       last_o
);
  localparam int unsigned DEPTH = 4;

  batch_t mem_q [DEPTH];
  logic [1:0] wp_q, rp_q, sel_q;
  logic [2:0] cnt_q;
  logic wr, rd, adv;
  batch_t head;

  assign head = mem_q[rp_q];
  assign wr = wr_i && !full_o && (batch_i.cnt != 3'd0);
  assign empty_o = (cnt_q == 3'd0);
  assign full_o = (cnt_q == 3'(DEPTH));
  assign rec_o = head.rec[sel_q];
  assign last_o = ({1'b0, sel_q} + 3'd1 == head.cnt);
  assign adv = pop_i && !empty_o;
  assign rd = adv && last_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= batch_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; sel_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      if (adv) sel_q <= rd ? 2'd0 : sel_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr) - 3'(rd);
    end
  end
endmodule
`default_nettype wire

// ----- sv/rexx_source_tokenizer.sv -----
// Top level of the streaming source tokenizer.
// Input channel: push with source_byte_i, byte_present_i, end_of_source_i;
//   a request is taken when push is high and full is low.
// Result channel: while empty is low the oldest token record is on the
//   result ports; pop takes it. last_of_run_o marks the final record of
//   the records one request caused (zero to four).
// Throughput: one request per cycle while full is low. The scanner
//   classifies a byte in the cycle it is taken and writes its records as
//   one batch into a four-entry queue; the result side reads one record
//   per cycle while pop is high and empty is low.
// When the receiver stalls the queue fills and full rises; input is then
//   held off until a batch is drained. Requests that cause no record do not
//   use a queue entry.
// Reset clears the scanner to its start of source state and empties the queue.
`default_nettype none
module rexx_source_tokenizer import rst_pkg::*; #(
  parameter int unsigned MAX_COMMENT_DEPTH = 255,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  source_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_source_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind_o,
  output logic             is_compound_o,
  output logic             is_constant_o,
  output logic             has_doubled_quote_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      text_length_o,
  output logic [15:0]      line_number_o,
  output logic [15:0]      column_number_o,
  output logic [2:0]       error_kind_o,
  output logic             last_of_run_o
);
  batch_t batch;
  rec_t rec;
  logic req;

  assign req = push && !full;

  rst_front #(.MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .req_i(req), .byte_i(source_byte_i), .present_i(byte_present_i),
    .eos_i(end_of_source_i), .batch_o(batch)
  );

  rst_back u_back (
    .clk_i, .rst_ni, .wr_i(req), .batch_i(batch), .full_o(full), .empty_o(empty),
    .pop_i(pop), .rec_o(rec), .last_o(last_of_run_o)
  );

  assign token_kind_o = rec.kind;
  assign is_compound_o = rec.comp;
  assign is_constant_o = rec.cons;
  assign has_doubled_quote_o = rec.dbl;
  assign start_offset_o = rec.off;
  assign text_length_o = rec.len;
  assign line_number_o = rec.line;
  assign column_number_o = rec.col;
  assign error_kind_o = rec.err;
endmodule
`default_nettype wire

// ----- sv/rst_checker.sv -----
// Port-level checks for the tokenizer, bound to the top level.
`default_nettype none
module rst_checker import rst_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [3:0] token_kind_o,
  input wire logic [2:0] error_kind_o,
  input wire logic       last_of_run_o
);
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((token_kind_o == K_ERR) == (error_kind_o != E_NONE))) else $error("err kind");
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_kind_o == K_EOF) |-> last_of_run_o) else $error("eof not last");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_kind_o == K_ERR) |-> last_of_run_o) else $error("error not last");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(token_kind_o))) else $error("record moved");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty) else $error("full and empty");
endmodule

bind rexx_source_tokenizer rst_checker u_rst_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .token_kind_o, .error_kind_o, .last_of_run_o
);
`default_nettype wire
